[sv/nvf_local_variance_mask_assert.svh]
`ifndef NVF_LOCAL_VARIANCE_MASK_ASSERT_SVH
`define NVF_LOCAL_VARIANCE_MASK_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NVFLV_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define NVFLV_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[sv/nvflv_pkg.sv]
`timescale 1ns / 1ps

package nvflv_pkg;

  localparam int WINDOW    = 3;
  localparam int MAX_COLS  = 2048;
  localparam int MAX_ROWS  = 2048;

  localparam int HALF      = WINDOW / 2;
  localparam int OFFS      = WINDOW / 2 - (WINDOW - 1) / 2;
  localparam int START     = OFFS + WINDOW - 1;
  localparam int LINES     = WINDOW - 1;
  localparam int PAD_W_MAX = MAX_COLS + 2 * HALF;
  localparam int PAD_H_MAX = MAX_ROWS + 2 * HALF;
  localparam int NN        = WINDOW * WINDOW;

  localparam int PIX_W     = 8;
  localparam int DIM_W     = 12;
  localparam int COORD_W   = 11;
  localparam int NVF_W     = 16;
  localparam int CMP_W     = 16;
  localparam int CNT_W     = $clog2(PAD_W_MAX);
  localparam int RCNT_W    = $clog2(PAD_H_MAX);
  localparam int S_W       = $clog2(NN * 255 + 1);
  localparam int Q_W       = $clog2(NN * 255 * 255 + 1);
  localparam int D_W       = $clog2(NN * NN * 255 * 255 + 1);
  localparam int REM_W     = D_W + 1;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;
  localparam logic [DIM_W-1:0]     DIM_RESET      = DIM_W'(512);

  // One classified window handed from the front end to the divider.
  typedef struct packed {
    logic [S_W-1:0]     s;
    logic [Q_W-1:0]     q;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } item_t;

endpackage

[sv/nvflv_ram.sv]
`timescale 1ns / 1ps

module nvflv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/nvflv_front.sv]
`timescale 1ns / 1ps

module nvflv_front import nvflv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [DIM_W-1:0]       image_cols,
  input  logic [DIM_W-1:0]       image_rows,
  input  logic [PIX_W-1:0]       pixel,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   ram_re,
  output logic [CNT_W-1:0]       ram_raddr,
  output logic                   ram_we,
  output logic [CNT_W-1:0]       ram_waddr,
  output logic [LINES*PIX_W-1:0] ram_wdata,
  input  logic [LINES*PIX_W-1:0] ram_rdata,
  output logic                   q_push,
  output item_t                  q_data,
  input  logic                   q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_SUM  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [PIX_W-1:0]   px;
  logic [CNT_W-1:0]   col_cnt;
  logic [RCNT_W-1:0]  row_cnt;
  logic [PIX_W-1:0]   win [WINDOW][WINDOW];
  logic [PIX_W-1:0]   column [WINDOW];
  logic [COORD_W-1:0] y_reg;
  logic [COORD_W-1:0] x_reg;
  logic               last_reg;
  logic [CMP_W-1:0]   cols_eff;
  logic [CMP_W-1:0]   rows_eff;
  logic [CMP_W-1:0]   pad_w;
  logic [CMP_W-1:0]   pad_h;
  logic [CMP_W-1:0]   r_ext;
  logic [CMP_W-1:0]   c_ext;
  logic [CMP_W-1:0]   y_ext;
  logic [CMP_W-1:0]   x_ext;
  logic               emit;
  logic [S_W-1:0]     s_sum;
  logic [Q_W-1:0]     q_sum;
  logic               in_xfer;

  assign in_ready  = (state == F_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign ram_re    = in_xfer;
  assign ram_raddr = col_cnt;
  assign ram_we    = (state == F_READ);
  assign ram_waddr = col_cnt;

  // Effective geometry, with out-of-range sizes saturated.
  always_comb begin
    cols_eff = CMP_W'(image_cols);
    if (cols_eff == '0) begin
      cols_eff = CMP_W'(1);
    end else if (cols_eff > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end
    rows_eff = CMP_W'(image_rows);
    if (rows_eff == '0) begin
      rows_eff = CMP_W'(1);
    end else if (rows_eff > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end
    pad_w = cols_eff + CMP_W'(2 * HALF);
    pad_h = rows_eff + CMP_W'(2 * HALF);
    r_ext = CMP_W'(row_cnt);
    c_ext = CMP_W'(col_cnt);
    y_ext = r_ext - CMP_W'(START);
    x_ext = c_ext - CMP_W'(START);
    emit  = (r_ext >= CMP_W'(START)) && (c_ext >= CMP_W'(START)) &&
            (y_ext < rows_eff) && (x_ext < cols_eff);
  end

  // The new column: older lines from the line store, the incoming pixel at the bottom.
  // Each line moves up by one when written back.
  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      column[k] = ram_rdata[k*PIX_W +: PIX_W];
    end
    column[LINES] = px;
    for (int k = 0; k < LINES; k++) begin
      ram_wdata[k*PIX_W +: PIX_W] = column[k+1];
    end
  end

  always_comb begin
    s_sum = '0;
    q_sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      for (int k = 0; k < WINDOW; k++) begin
        s_sum = s_sum + S_W'(win[i][k]);
        q_sum = q_sum + Q_W'((2*PIX_W)'(win[i][k]) * (2*PIX_W)'(win[i][k]));
      end
    end
  end

  assign q_push = (state == F_SUM) && !q_full;
  assign q_data = '{s: s_sum, q: q_sum, row: y_reg, col: x_reg, last: last_reg};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (in_xfer) begin
          state_next = F_READ;
        end
      end
      F_READ: begin
        state_next = emit ? F_SUM : F_IDLE;
      end
      F_SUM: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      col_cnt <= '0;
      row_cnt <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        for (int k = 0; k < WINDOW; k++) begin
          win[i][k] <= '0;
        end
      end
    end else begin
      state <= state_next;
      if (state == F_READ) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[WINDOW-1] <= column;
        // Raster position advance; a position left beyond a shrunken frame wraps here.
        if (c_ext + CMP_W'(1) >= pad_w) begin
          col_cnt <= '0;
          row_cnt <= (r_ext + CMP_W'(1) >= pad_h) ? '0 : RCNT_W'(r_ext + CMP_W'(1));
        end else begin
          col_cnt <= CNT_W'(c_ext + CMP_W'(1));
          if (r_ext >= pad_h) begin
            row_cnt <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px <= pixel;
    end
    if (state == F_READ) begin
      y_reg    <= COORD_W'(y_ext);
      x_reg    <= COORD_W'(x_ext);
      last_reg <= (y_ext == rows_eff - CMP_W'(1)) && (x_ext == cols_eff - CMP_W'(1));
    end
  end

endmodule

[sv/nvflv_queue.sv]
`timescale 1ns / 1ps

module nvflv_queue import nvflv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign full     = (count == CNT_QW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_QW'(1);
      end else if (pop && !push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[sv/nvflv_back.sv]
`timescale 1ns / 1ps

module nvflv_back import nvflv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  item_t              q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NVF_W-1:0]   nvf_value,
  output logic [COORD_W-1:0] out_row,
  output logic [COORD_W-1:0] out_col,
  output logic               frame_last
);

  localparam int STEP_W = $clog2(NVF_W);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQ   = 3'd1;
  localparam logic [2:0] B_PREP = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  logic [2:0]         state;
  logic [2:0]         state_next;
  item_t              cur;
  logic [2*S_W-1:0]   sq;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   den;
  logic [NVF_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic [REM_W-1:0]   d_val;
  logic [REM_W:0]     rem2;
  logic               ge;
  logic               out_free;

  assign q_pop    = (state == B_IDLE) && !q_empty;
  assign out_free = !out_valid || out_ready;

  // D = N*Q - S*S; the square is registered in the cycle before.
  assign d_val = REM_W'(cur.q) * REM_W'(NN) - REM_W'(sq);

  // One restoring step: the remainder stays below the divisor, so the
  // quotient fits in NVF_W bits.
  assign rem2 = {rem, 1'b0};
  assign ge   = (rem2 >= {1'b0, den});

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = B_SQ;
        end
      end
      B_SQ: begin
        state_next = B_PREP;
      end
      B_PREP: begin
        state_next = B_DIV;
      end
      B_DIV: begin
        if (step == STEP_W'(NVF_W - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == B_SQ) begin
      sq <= (2*S_W)'(cur.s) * (2*S_W)'(cur.s);
    end
    if (state == B_PREP) begin
      rem  <= d_val;
      den  <= d_val + REM_W'(NN * NN);
      quo  <= '0;
      step <= '0;
    end
    if (state == B_DIV) begin
      rem  <= ge ? REM_W'(rem2 - {1'b0, den}) : REM_W'(rem2);
      quo  <= {quo[NVF_W-2:0], ge};
      step <= step + STEP_W'(1);
    end
    if (state == B_DONE && out_free) begin
      nvf_value  <= quo;
      out_row    <= cur.row;
      out_col    <= cur.col;
      frame_last <= cur.last;
    end
  end

endmodule

[sv/nvf_local_variance_mask.sv]
`timescale 1ns / 1ps
`include "nvf_local_variance_mask_assert.svh"

// Local-variance mask over a 3x3 neighborhood. Feed the image in raster order with a
// one-pixel zero border already around it, so each frame is (image_cols+2) x
// (image_rows+2) pixels; one result comes out for each real pixel, tagged with its row
// and column, and frame_last marks the last one. Each value is floor(65536*D/(81+D))
// with D = 9*Q - S*S over the window, i.e. variance/(1+variance) in unsigned Q0.16.
// The front end takes one pixel at a time, with a line-store read, then write-back, and
// a summing state when the pixel closes a window, held while the queue is full. Each
// result then passes the back end's square, prepare, divide and done states, dominated
// by a bit-serial divider that makes one quotient bit per cycle; a 4-entry queue lets
// the front end run ahead across border pixels. Program image_cols and image_rows only
// while the block is idle; the line store needs no clearing after reset.
module nvf_local_variance_mask import nvflv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [PIX_W-1:0]     pixel,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic [NVF_W-1:0]     nvf_value,
  output logic [COORD_W-1:0]   out_row,
  output logic [COORD_W-1:0]   out_col,
  output logic                 frame_last,
  output logic                 out_valid,
  input  logic                 out_ready
);

  logic [DIM_W-1:0]       image_cols;
  logic [DIM_W-1:0]       image_rows;
  logic                   ram_re;
  logic                   ram_we;
  logic [CNT_W-1:0]       ram_raddr;
  logic [CNT_W-1:0]       ram_waddr;
  logic [LINES*PIX_W-1:0] ram_wdata;
  logic [LINES*PIX_W-1:0] ram_rdata;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  item_t                  q_in;
  item_t                  q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= DIM_RESET;
      image_rows <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: image_cols <= cfg_data;
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  nvflv_ram #(
    .WIDTH (LINES * PIX_W),
    .DEPTH (PAD_W_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nvflv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .image_cols (image_cols),
    .image_rows (image_rows),
    .pixel      (pixel),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .q_push     (q_push),
    .q_data     (q_in),
    .q_full     (q_full)
  );

  nvflv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  nvflv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .nvf_value  (nvf_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last)
  );

  // The front end never pushes into a full queue, the back end never pops an empty one,
  // and a pixel transfer is always followed by its line-store turnaround.
  `NVFLV_ASSERT_IMPL(a_push_has_room, clk, rst, q_push, !q_full)
  `NVFLV_ASSERT_IMPL(a_pop_has_data, clk, rst, q_pop, !q_empty)
  `NVFLV_ASSERT_NEXT(a_pixel_turnaround, clk, rst, in_valid && in_ready, !in_ready)

endmodule

[test/tb_nvf_local_variance_mask.sv]
`timescale 1ns / 1ps

module tb_nvf_local_variance_mask;
  import nvflv_pkg::*;

  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 220;
  localparam int MAX_SHOWN      = 10;

  typedef struct packed {
    logic [NVF_W-1:0]   nvf;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } mask_result_t;

  typedef enum {FILL_RANDOM, FILL_FLAT, FILL_BINARY, FILL_CHECKER, FILL_LOW_CONTRAST} fill_t;
  typedef enum {BORDER_ZERO, BORDER_NOISE, BORDER_FILL} border_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic [PIX_W-1:0]     pixel;
  logic                 in_valid;
  logic                 in_ready;
  logic [NVF_W-1:0]     nvf_value;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic                 frame_last;
  logic                 out_valid;
  logic                 out_ready;

  nvf_local_variance_mask dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel      (pixel),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .nvf_value  (nvf_value),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (frame_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  always #5 clk = ~clk;

  // Mirror of the block: size registers, line buffers, window and raster position.
  logic [DIM_W-1:0] cols_reg = DIM_RESET;
  logic [DIM_W-1:0] rows_reg = DIM_RESET;
  logic [PIX_W-1:0] line_buf [LINES][PAD_W_MAX];
  logic [PIX_W-1:0] win [WINDOW][WINDOW];
  int unsigned      pos_row = 0;
  int unsigned      pos_col = 0;
  mask_result_t     pending_masks [$];

  // Stimulus controls.
  fill_t            fill_mode = FILL_RANDOM;
  border_t          border_mode = BORDER_ZERO;
  logic [PIX_W-1:0] fill_level = '0;
  int unsigned      tx_gap_odds = 0;
  bit               rx_idle_on = 1'b1;
  int unsigned      rx_hold_left = 0;
  int unsigned      rx_burst_left = 0;
  int unsigned      rx_calm_left = 0;

  // Bookkeeping.
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done = 0;
  int unsigned size_settings = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_stall_cycles = 0;
  mask_result_t got_mask;
  mask_result_t want_mask;

  function automatic int unsigned saturate_size(input logic [DIM_W-1:0] v,
                                                input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void predict_mask_pixel(input logic [PIX_W-1:0] px);
    int unsigned cols, rows, pad_w, pad_h, r, c, y, x;
    logic [PIX_W-1:0] column [WINDOW];
    longint unsigned s, q, d, v;
    mask_result_t res;
    cols  = saturate_size(cols_reg, MAX_COLS);
    rows  = saturate_size(rows_reg, MAX_ROWS);
    pad_w = cols + 2 * HALF;
    pad_h = rows + 2 * HALF;
    r = pos_row;
    c = pos_col;
    for (int k = 0; k < LINES; k++) column[k] = (c < PAD_W_MAX) ? line_buf[k][c] : '0;
    column[WINDOW-1] = px;
    if (c < PAD_W_MAX)
      for (int k = 0; k < LINES; k++) line_buf[k][c] = column[k+1];
    for (int i = 0; i < WINDOW - 1; i++)
      for (int k = 0; k < WINDOW; k++) win[i][k] = win[i+1][k];
    for (int k = 0; k < WINDOW; k++) win[WINDOW-1][k] = column[k];

    if (r >= START && c >= START) begin
      y = r - START;
      x = c - START;
      if (y < rows && x < cols) begin
        s = 0;
        q = 0;
        for (int i = 0; i < WINDOW; i++)
          for (int k = 0; k < WINDOW; k++) begin
            v = win[i][k];
            s += v;
            q += v * v;
          end
        d = NN * q - s * s;
        res.nvf  = NVF_W'((d << 16) / (NN * NN + d));
        res.row  = COORD_W'(y);
        res.col  = COORD_W'(x);
        res.last = (y == rows - 1 && x == cols - 1);
        pending_masks.push_back(res);
      end
    end

    // A position left outside a shrunken frame wraps at this pixel.
    if (c + 1 >= pad_w) begin
      pos_col = 0;
      pos_row = (r + 1 >= pad_h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      if (r >= pad_h) pos_row = 0;
    end
    if (pos_row == 0 && pos_col == 0) frames_done++;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned cols, rows;
    bit border;
    cols   = saturate_size(cols_reg, MAX_COLS);
    rows   = saturate_size(rows_reg, MAX_ROWS);
    border = pos_row < HALF || pos_col < HALF ||
             pos_row >= HALF + rows || pos_col >= HALF + cols;
    if (border && border_mode == BORDER_ZERO) return '0;
    if (border && border_mode == BORDER_NOISE) return PIX_W'($urandom_range(0, 255));
    case (fill_mode)
      FILL_FLAT:         return fill_level;
      FILL_BINARY:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      FILL_CHECKER:      return ((pos_row + pos_col) % 2) ? 8'hFF : 8'h00;
      FILL_LOW_CONTRAST: return fill_level + PIX_W'($urandom_range(0, 3));
      default:           return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel and returns right after its transfer, with valid still high.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int unsigned gap;
    if (tx_gap_odds != 0 && $urandom_range(0, tx_gap_odds) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    pixel    <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    predict_mask_pixel(px);
  endtask

  task automatic send_run(input int unsigned count);
    repeat (count) send_pixel(pick_pixel());
  endtask

  // Sends at least one pixel and stops once the raster position is back at the origin.
  task automatic send_frame();
    do send_pixel(pick_pixel()); while (pos_row != 0 || pos_col != 0);
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DIM_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_COLS) cols_reg = value;
    else if (idx == REG_IMAGE_ROWS) rows_reg = value;
  endtask

  // Registers change only once the block has gone quiet.
  task automatic resize_image(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    pause_sender();
    wait_drained();
    write_size_reg(REG_IMAGE_COLS, cols);
    write_size_reg(REG_IMAGE_ROWS, rows);
    size_settings++;
  endtask

  task automatic set_fill(input fill_t f, input border_t b, input logic [PIX_W-1:0] level);
    fill_mode   = f;
    border_mode = b;
    fill_level  = level;
  endtask

  task automatic pick_random_fill();
    set_fill(fill_t'($urandom_range(0, 4)),
             ($urandom_range(0, 5) == 0) ? BORDER_NOISE : BORDER_ZERO,
             PIX_W'($urandom_range(0, 252)));
  endtask

  // A short run on the reset width of 512 leaves the position at column 20 of row 0,
  // so the shrink in the middle of the frame wraps it into the next row. The run also
  // writes every line-store column that the narrow frames later read.
  task automatic test_reset_size_and_midframe_write();
    set_fill(FILL_RANDOM, BORDER_ZERO, '0);
    tx_gap_odds = 7;
    send_run(20);
    resize_image(12'd2, 12'd2);
    send_frame();
  endtask

  task automatic test_size_extremes();
    tx_gap_odds = 0;
    resize_image(12'd0, 12'd0);
    set_fill(FILL_FLAT, BORDER_ZERO, 8'hFF);
    send_frame();
    resize_image(12'd1, 12'd1);
    set_fill(FILL_FLAT, BORDER_NOISE, 8'h00);
    send_frame();
    resize_image(12'd3, 12'd3);
    set_fill(FILL_CHECKER, BORDER_FILL, '0);
    send_frame();
    set_fill(FILL_FLAT, BORDER_FILL, 8'hFF);
    send_frame();
  endtask

  // Shrink while the position lies beyond the new rows, then beyond both dimensions.
  task automatic test_position_wrap();
    set_fill(FILL_RANDOM, BORDER_ZERO, '0);
    tx_gap_odds = 3;
    resize_image(12'd8, 12'd6);
    send_run(5 * 10 + 2);
    resize_image(12'd3, 12'd2);
    send_frame();
    resize_image(12'd8, 12'd6);
    send_run(5 * 10 + 7);
    resize_image(12'd3, 12'd2);
    send_frame();
    send_frame();
  endtask

  // Out-of-range sizes saturate; short runs on them end in a shrink that wraps the position.
  task automatic test_clamped_sizes();
    tx_gap_odds = 15;
    set_fill(FILL_RANDOM, BORDER_ZERO, '0);
    resize_image(12'd4095, 12'd4095);
    send_run(40);
    set_fill(FILL_LOW_CONTRAST, BORDER_ZERO, 8'd120);
    resize_image(12'd0, 12'd3);
    send_frame();
    set_fill(FILL_BINARY, BORDER_NOISE, '0);
    resize_image(12'd0, 12'd4095);
    send_run(12 * (1 + 2 * HALF));
    resize_image(12'd2, 12'd2);
    send_frame();
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    tx_gap_odds = 0;
    set_fill(FILL_RANDOM, BORDER_ZERO, '0);
    resize_image(12'd6, 12'd6);
    rx_hold_left = HOLD_CYCLES;
    send_frame();
    pause_sender();
    wait_drained();
    send_frame();
  endtask

  task automatic test_random_frames();
    int unsigned start_count;
    int unsigned cols, rows;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       tx_gap_odds = 0;
        1:       tx_gap_odds = 3;
        default: tx_gap_odds = 15;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        cols = $urandom_range(20, 40);
        rows = $urandom_range(1, 3);
      end else begin
        cols = $urandom_range(1, 16);
        rows = $urandom_range(1, 8);
      end
      resize_image(DIM_W'(cols), DIM_W'(rows));
      pick_random_fill();
      if ($urandom_range(0, 5) == 0) begin
        // Broken frame: resize partway through and let the position sort itself out.
        send_run($urandom_range(1, (cols + 2 * HALF) * (rows + 2 * HALF) - 1));
        resize_image(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 8)));
      end
      send_frame();
    end
  endtask

  task automatic test_back_to_back_streaming();
    tx_gap_odds = 0;
    rx_idle_on  = 1'b0;
    resize_image(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 6)));
    repeat (2) begin
      pick_random_fill();
      send_frame();
    end
  endtask

  task automatic finish_run();
    pause_sender();
    wait_drained();
    $display("Checked %0d mask results from %0d pixels in %0d frames over %0d size settings.",
             results_checked, pixels_sent, frames_done, size_settings);
    $display("Covered saturated sizes, mid-frame resizes, a long output hold and %0d %s",
             in_stall_cycles, "input stall cycles.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_COLS;
    cfg_data  = '0;
    pixel     = '0;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    for (int k = 0; k < LINES; k++)
      for (int c = 0; c < PAD_W_MAX; c++) line_buf[k][c] = '0;
    for (int i = 0; i < WINDOW; i++)
      for (int k = 0; k < WINDOW; k++) win[i][k] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_size_and_midframe_write();
    test_size_extremes();
    test_position_wrap();
    test_clamped_sizes();
    test_output_backpressure();
    test_random_frames();
    test_back_to_back_streaming();
    finish_run();
  end

  // Receiver: a long hold when asked, otherwise random stall bursts between calm stretches.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && rx_calm_left == 0 && $urandom_range(0, 11) == 0) begin
      rx_burst_left = $urandom_range(0, 16);
      rx_calm_left  = $urandom_range(0, 80);
      out_ready <= 1'b0;
    end else begin
      if (rx_calm_left > 0) rx_calm_left--;
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_mask = '{nvf: nvf_value, row: out_row, col: out_col, last: frame_last};
      results_checked++;
      if (pending_masks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN)
          $display("%0t: unexpected result nvf=%0d row=%0d col=%0d last=%0b",
                   $realtime, got_mask.nvf, got_mask.row, got_mask.col, got_mask.last);
      end else begin
        want_mask = pending_masks.pop_front();
        if (got_mask.nvf !== want_mask.nvf || got_mask.row !== want_mask.row ||
            got_mask.col !== want_mask.col || got_mask.last !== want_mask.last) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display({"%0t: expected nvf=%0d row=%0d col=%0d last=%0b, ",
                      "got nvf=%0d row=%0d col=%0d last=%0b"},
                     $realtime, want_mask.nvf, want_mask.row, want_mask.col, want_mask.last,
                     got_mask.nvf, got_mask.row, got_mask.col, got_mask.last);
        end
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) in_stall_cycles++;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results still expected.",
               quiet_cycles, pending_masks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

[nvf_local_variance_mask.f]
+incdir+sv
sv/nvflv_pkg.sv
sv/nvflv_ram.sv
sv/nvflv_front.sv
sv/nvflv_queue.sv
sv/nvflv_back.sv
sv/nvf_local_variance_mask.sv
test/tb_nvf_local_variance_mask.sv
